// ----- hw/rtl/telnet_option_negotiator_unit_macros.svh -----
// ---------------------------------------------------------------------------
// telnet option negotiator assertion macros
// shared concurrent assertion forms, synchronous reset disables checking
// ---------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_UNIT_MACROS_SVH
`define TELNET_OPTION_NEGOTIATOR_UNIT_MACROS_SVH

// same-cycle implication
`define TONU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TONU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tonu_pkg.sv -----
// ---------------------------------------------------------------------------
// tonu_pkg
// types, protocol constants and reply byte tables of the option negotiator
// ---------------------------------------------------------------------------
package tonu_pkg;

  localparam logic [7:0] IAC       = 8'hff;
  localparam logic [7:0] CMD_DONT  = 8'hfe;
  localparam logic [7:0] CMD_DO    = 8'hfd;
  localparam logic [7:0] CMD_WONT  = 8'hfc;
  localparam logic [7:0] CMD_WILL  = 8'hfb;
  localparam logic [7:0] CMD_SUB   = 8'hfa;
  localparam logic [7:0] CMD_SE    = 8'hf0;
  localparam logic [7:0] OPT_ECHO  = 8'h01;
  localparam logic [7:0] OPT_SGA   = 8'h03;
  localparam logic [7:0] OPT_TTYPE = 8'h18;
  localparam logic [7:0] OPT_NENV  = 8'h27;

  // action kinds queued between front and back
  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_TTYPE = 2'd2;
  localparam logic [1:0] ACT_NENV  = 2'd3;

  localparam logic [0:0] DEST_TERM = 1'b0;
  localparam logic [0:0] DEST_PEER = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] verb;
    logic [7:0] arg;
  } act_t;

  typedef struct packed {
    logic valid;
    act_t act;
  } push_t;

  // index of the final byte of each burst
  function automatic logic [3:0] burst_end(logic [1:0] kind);
    logic [3:0] r;
    case (kind)
      ACT_DATA:  r = 4'd0;
      ACT_REPLY: r = 4'd2;
      ACT_TTYPE: r = 4'd10;
      ACT_NENV:  r = 4'd5;
      default:   r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ttype_byte(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = IAC;
      4'd1:    r = CMD_SUB;
      4'd2:    r = OPT_TTYPE;
      4'd3:    r = 8'h00;
      4'd4:    r = 8'h76;
      4'd5:    r = 8'h74;
      4'd6:    r = 8'h31;
      4'd7:    r = 8'h30;
      4'd8:    r = 8'h30;
      4'd9:    r = IAC;
      4'd10:   r = CMD_SE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] nenv_byte(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = IAC;
      4'd1:    r = CMD_SUB;
      4'd2:    r = OPT_NENV;
      4'd3:    r = 8'h00;
      4'd4:    r = IAC;
      4'd5:    r = CMD_SE;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] reply_byte(act_t a, logic [3:0] idx);
    logic [7:0] r;
    case (a.kind)
      ACT_DATA:  r = a.arg;
      ACT_REPLY: begin
        case (idx)
          4'd0:    r = IAC;
          4'd1:    r = a.verb;
          default: r = a.arg;
        endcase
      end
      ACT_TTYPE: r = ttype_byte(idx);
      ACT_NENV:  r = nenv_byte(idx);
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/telnet_option_negotiator_unit.sv -----
// ---------------------------------------------------------------------------
// telnet_option_negotiator_unit
// telnet byte stream filter with option negotiation replies
// ---------------------------------------------------------------------------
// usage:
//   s_* carries bytes received from the peer, one byte per transaction.
//   m_* delivers results: m_tuser 0 marks a data byte for the terminal,
//   1 a reply byte for the peer; m_tlast closes the results of one input.
//   command bytes (iac, verb, option, and three bytes after a sub option)
//   produce no data byte for the terminal; a reply burst has 3, 6 or 11 bytes.
// path: an accepted byte's action is written into the queue, and its result
//   bytes then leave through the output register on m_*.
// throughput: one input byte per cycle while results flow; the burst
//   generator emits one output byte per cycle while m_tready is high, so a
//   reply burst holds its action in the queue and input stalls once it is full.
// reset: parser returns to plain data, queue and output register empty.
// stall: when m_tready is low the output register holds, the queue fills
//   and s_tready drops once DEPTH actions are waiting.
// ---------------------------------------------------------------------------
module telnet_option_negotiator_unit #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] destination
  output logic       m_tlast
);
  import tonu_pkg::*;

  push_t push;
  act_t  head;
  logic  full, head_valid, pop;

  assign s_tready = !full;

  tonu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_tvalid && s_tready),
    .rx_byte (s_tdata),
    .push    (push)
  );

  tonu_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tonu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_dest   (m_tuser),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ----- hw/rtl/tonu_front.sv -----
// ---------------------------------------------------------------------------
// tonu_front
// command parser: classifies each received byte, and turns data and replies into a queued action
// ---------------------------------------------------------------------------
module tonu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output tonu_pkg::push_t     push
);
  import tonu_pkg::*;

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_OPT  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] command_held, command_held_next;
  logic [1:0] skip_left, skip_left_next;
  push_t      push_next;

  always_comb begin
    phase_next        = phase;
    command_held_next = command_held;
    skip_left_next    = skip_left;
    push_next         = '0;
    push_next.act.arg = rx_byte;
    case (phase)
      PH_DATA: begin
        if (rx_byte == IAC) begin
          phase_next = PH_CMD;
        end else begin
          push_next.valid    = 1'b1;
          push_next.act.kind = ACT_DATA;
        end
      end
      PH_CMD: begin
        command_held_next = rx_byte;
        phase_next        = PH_OPT;
      end
      PH_OPT: begin
        phase_next = PH_DATA;
        case (command_held)
          CMD_DO: begin
            push_next.act.kind = ACT_REPLY;
            if (rx_byte inside {OPT_TTYPE, OPT_NENV, OPT_ECHO}) begin
              push_next.valid    = 1'b1;
              push_next.act.verb = CMD_WILL;
            end else if (rx_byte != OPT_SGA) begin
              push_next.valid    = 1'b1;
              push_next.act.verb = CMD_WONT;
            end
          end
          CMD_WILL: begin
            push_next.valid    = 1'b1;
            push_next.act.kind = ACT_REPLY;
            push_next.act.verb = CMD_DO;
          end
          CMD_WONT: begin
            push_next.valid    = 1'b1;
            push_next.act.kind = ACT_REPLY;
            push_next.act.verb = CMD_DONT;
          end
          CMD_SUB: begin
            if (rx_byte == OPT_TTYPE) begin
              push_next.valid    = 1'b1;
              push_next.act.kind = ACT_TTYPE;
            end else if (rx_byte == OPT_NENV) begin
              push_next.valid    = 1'b1;
              push_next.act.kind = ACT_NENV;
            end
            phase_next     = PH_SKIP;
            skip_left_next = 2'd3;
          end
          default: ;
        endcase
      end
      default: begin
        // three bytes after a sub option are dropped unseen
        if (skip_left != 2'd0) skip_left_next = skip_left - 2'd1;
        if (skip_left_next == 2'd0) phase_next = PH_DATA;
      end
    endcase
    push_next.valid = push_next.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DATA;
      command_held <= 8'h00;
      skip_left    <= 2'd0;
    end else if (accept) begin
      phase        <= phase_next;
      command_held <= command_held_next;
      skip_left    <= skip_left_next;
    end
  end

  assign push = push_next;

endmodule

// ----- hw/rtl/tonu_queue.sv -----
// ---------------------------------------------------------------------------
// tonu_queue
// short action queue decoupling the parser from the burst generator
// ---------------------------------------------------------------------------
`include "telnet_option_negotiator_unit_macros.svh"

module tonu_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  tonu_pkg::push_t push,
  output logic            full,
  output logic            head_valid,
  output tonu_pkg::act_t  head,
  input  logic            pop
);
  import tonu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  act_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;
  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TONU_ASSERT_IMP(a_no_drop, clk, rst, push.valid, !full, "action pushed into full queue")
  `TONU_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, head_valid, "pop from empty queue")
  `TONU_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_FULL, "queue count overflow")

endmodule

// ----- hw/rtl/tonu_back.sv -----
// ---------------------------------------------------------------------------
// tonu_back
// burst generator: expands queued actions into output bytes
// ---------------------------------------------------------------------------
`include "telnet_option_negotiator_unit_macros.svh"

module tonu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tonu_pkg::act_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_dest,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import tonu_pkg::*;

  logic [3:0] idx;
  logic       advance, last_beat;

  assign advance   = head_valid && (!out_valid || out_ready);
  assign last_beat = (idx == burst_end(head.kind));
  assign pop       = advance && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= last_beat ? 4'd0 : idx + 4'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dest <= (head.kind == ACT_DATA) ? DEST_TERM : DEST_PEER;
      out_byte <= reply_byte(head, idx);
      out_last <= last_beat;
    end
  end

  `TONU_ASSERT_IMP(a_idx_in_burst, clk, rst, head_valid,
    idx <= burst_end(head.kind), "burst index past end of burst")
  `TONU_ASSERT_IMP(a_data_single, clk, rst, out_valid && out_dest == DEST_TERM,
    out_last, "terminal byte not marked last")
  `TONU_ASSERT_NEXT(a_idx_restart, clk, rst, pop, idx == 4'd0,
    "burst index not cleared after pop")

endmodule

// ----- tb/sv/tb_telnet_option_negotiator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_telnet_option_negotiator_unit
// stream-level test of the telnet option negotiator: received bytes are sent
// with random gaps, every output byte is checked in order against a local
// model of the command parser and its reply bursts
// ---------------------------------------------------------------------------
module tb_telnet_option_negotiator_unit;
  import tonu_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  typedef enum logic [1:0] {PH_DATA, PH_CMD, PH_OPT, PH_SKIP} parse_phase_t;

  typedef struct {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } out_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  out_byte_t    bytes_due[$];
  parse_phase_t phase = PH_DATA;
  logic [7:0]   cmd_held = 8'h00;
  logic [1:0]   skip_left = 2'd0;

  int mismatches = 0;
  int items_sent = 0;
  int in_gap_max = 5;
  int out_gap_max = 5;
  int idle_cycles = 0;

  telnet_option_negotiator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // parser model: advances on one received byte and queues what it must emit
  function automatic void negotiate_byte(input logic [7:0] b);
    logic [7:0] burst[$];
    logic       to_peer;
    out_byte_t  ob;
    burst = {};
    to_peer = DEST_PEER;
    case (phase)
      PH_DATA: begin
        if (b == IAC) begin
          phase = PH_CMD;
        end else begin
          to_peer = DEST_TERM;
          burst.push_back(b);
        end
      end
      PH_CMD: begin
        cmd_held = b;
        phase = PH_OPT;
      end
      PH_OPT: begin
        phase = PH_DATA;
        case (cmd_held)
          CMD_DO: begin
            if (b == OPT_TTYPE || b == OPT_NENV || b == OPT_ECHO)
              burst = {IAC, CMD_WILL, b};
            else if (b != OPT_SGA)
              burst = {IAC, CMD_WONT, b};
          end
          CMD_WILL: burst = {IAC, CMD_DO, b};
          CMD_WONT: burst = {IAC, CMD_DONT, b};
          CMD_SUB: begin
            // terminal type answer carries the name "vt100"
            if (b == OPT_TTYPE)
              burst = {IAC, CMD_SUB, OPT_TTYPE, 8'h00, 8'h76, 8'h74, 8'h31, 8'h30,
                       8'h30, IAC, CMD_SE};
            else if (b == OPT_NENV)
              burst = {IAC, CMD_SUB, OPT_NENV, 8'h00, IAC, CMD_SE};
            phase = PH_SKIP;
            skip_left = 2'd3;
          end
          default: ;
        endcase
      end
      default: begin
        if (skip_left != 2'd0)
          skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0)
          phase = PH_DATA;
      end
    endcase
    foreach (burst[i]) begin
      ob.dest = to_peer;
      ob.data = burst[i];
      ob.last = (i == burst.size() - 1);
      bytes_due.push_back(ob);
    end
  endfunction

  // one input transaction, then the gap before the next one
  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    negotiate_byte(b);
    items_sent++;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(IAC);
    send_byte(cmd);
    send_byte(opt);
  endtask

  task automatic send_random_sequence();
    logic [7:0] cmd;
    logic [7:0] opt;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(8'($urandom_range(0, 254)));
      4: send_byte(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 5))
          0: cmd = CMD_DO;
          1: cmd = CMD_DONT;
          2: cmd = CMD_WILL;
          3: cmd = CMD_WONT;
          4: cmd = CMD_SUB;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
          0: opt = OPT_TTYPE;
          1: opt = OPT_NENV;
          2: opt = OPT_ECHO;
          3: opt = OPT_SGA;
          default: opt = 8'($urandom_range(0, 255));
        endcase
        // occasionally cut the command short with stray bytes
        if ($urandom_range(0, 9) == 0) begin
          send_byte(IAC);
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_command(cmd, opt);
          if (cmd == CMD_SUB)
            repeat (3) send_byte(8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic test_plain_data();
    send_byte(8'h00);
    send_byte(8'hfe);
  endtask

  task automatic test_option_replies();
    send_command(CMD_DO, OPT_TTYPE);
    send_command(CMD_DO, OPT_SGA);
    send_command(CMD_DO, 8'hff);
    send_command(CMD_WILL, OPT_ECHO);
    send_command(CMD_WONT, 8'h00);
    send_command(CMD_DONT, OPT_NENV);
  endtask

  task automatic test_subnegotiation();
    // iac bytes inside the skipped tail must not open a command
    send_command(CMD_SUB, OPT_TTYPE);
    repeat (3) send_byte(IAC);
    send_command(CMD_SUB, OPT_NENV);
    repeat (3) send_byte(8'h00);
    send_command(CMD_SUB, OPT_ECHO);
    repeat (3) send_byte(8'h5a);
  endtask

  task automatic test_odd_commands();
    // doubled iac, then an unknown verb
    send_command(IAC, OPT_TTYPE);
    send_command(8'hf1, OPT_ECHO);
  endtask

  task automatic test_random_stream(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at)
      send_random_sequence();
  endtask

  task automatic test_drain_pause();
    send_command(CMD_SUB, OPT_TTYPE);
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    send_command(CMD_DO, OPT_ECHO);
  endtask

  task automatic test_back_to_back(input int count);
    in_gap_max  = 0;
    out_gap_max = 0;
    test_random_stream(count);
    in_gap_max  = 5;
    out_gap_max = 5;
  endtask

  // output side: random stalls, and every transaction checked in order
  initial begin
    int        gap;
    out_byte_t ob;
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (bytes_due.size() == 0) begin
        mismatches++;
        $display("%0t unexpected output: dest=%0d byte=%02h last=%0d",
                 $time, m_tuser, m_tdata, m_tlast);
      end else begin
        ob = bytes_due.pop_front();
        if (m_tuser !== ob.dest || m_tdata !== ob.data || m_tlast !== ob.last) begin
          mismatches++;
          $display({"%0t mismatch: expected dest=%0d byte=%02h last=%0d,",
                    " got dest=%0d byte=%02h last=%0d"},
                   $time, ob.dest, ob.data, ob.last, m_tuser, m_tdata, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_data();
    test_option_replies();
    test_subnegotiation();
    test_odd_commands();
    test_random_stream(45);
    test_drain_pause();
    test_back_to_back(40);
    test_random_stream(30);
    s_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- telnet_option_negotiator_unit.f -----
+incdir+hw/rtl
hw/rtl/tonu_pkg.sv
hw/rtl/tonu_front.sv
hw/rtl/tonu_queue.sv
hw/rtl/tonu_back.sv
hw/rtl/telnet_option_negotiator_unit.sv
tb/sv/tb_telnet_option_negotiator_unit.sv
